/* sv/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bcm_pkg.sv */
`default_nettype none

package bcm_pkg;

    localparam int NUM_LEDS   = 8;
    localparam int NUM_PLANES = 8;
    localparam int LEVEL_W    = 8;
    localparam int SLICE_W    = 3;
    localparam int HOLD_W     = 16;

    // smallest usable slice unit; a zero register setting is read as this
    localparam logic [7:0] UNIT_MIN = 8'h01;

    // request modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // register map (word index)
    localparam logic REG_TICKS_PER_UNIT = 1'b0;

    typedef logic [NUM_LEDS-1:0] pattern_t;
    typedef pattern_t [NUM_PLANES-1:0] planes_t;

    typedef struct packed {
        logic                    mode;
        logic [NUM_LEDS-1:0]     led_mask;
        logic [LEVEL_W-1:0]      level_0;
        logic [LEVEL_W-1:0]      level_1;
        logic [LEVEL_W-1:0]      level_2;
        logic [LEVEL_W-1:0]      level_3;
        logic [LEVEL_W-1:0]      level_4;
        logic [LEVEL_W-1:0]      level_5;
        logic [LEVEL_W-1:0]      level_6;
        logic [LEVEL_W-1:0]      level_7;
    } in_t;

    typedef struct packed {
        logic [NUM_LEDS-1:0]     port_value;
        logic [SLICE_W-1:0]      slice_now;
        logic                    load_taken;
    } out_t;

endpackage

`default_nettype wire

/* sv/bcm_transpose.sv */
`default_nettype none

// Bit-plane transpose: plane k, bit n = mask[n] & level_n[k].
module bcm_transpose (
    input  wire bcm_pkg::in_t    req,
    output bcm_pkg::planes_t     planes
);

    logic [bcm_pkg::LEVEL_W-1:0] levels [bcm_pkg::NUM_LEDS];

    always_comb begin
        levels[0] = req.level_0;
        levels[1] = req.level_1;
        levels[2] = req.level_2;
        levels[3] = req.level_3;
        levels[4] = req.level_4;
        levels[5] = req.level_5;
        levels[6] = req.level_6;
        levels[7] = req.level_7;
    end

    always_comb begin
        for (int k = 0; k < bcm_pkg::NUM_PLANES; k++) begin
            for (int n = 0; n < bcm_pkg::NUM_LEDS; n++) begin
                planes[k][n] = req.led_mask[n] & levels[n][k];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/bcm_led_driver.sv */
// A request's result is registered into the output register when the request is accepted.
// Throughput: one request per cycle; input stalls only while a result waits and m_ready is low.
// Rate set by the single compare/increment of the slice timer and the combinational transpose.
// Reset (aresetn low, synchronous): both buffers zero, slice 0, counter 0, shown pattern dark,
// no swap pending, ticks_per_unit = 1, output register empty.
`default_nettype none
`include "assert_macros.svh"

module bcm_led_driver (
    input  wire                aclk,
    input  wire                aresetn,
    // request channel
    input  wire                s_valid,
    output logic               s_ready,
    input  wire bcm_pkg::in_t  s_data,
    // result channel
    output logic               m_valid,
    input  wire                m_ready,
    output bcm_pkg::out_t      m_data,
    // configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [7:0] tpu_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == bcm_pkg::REG_TICKS_PER_UNIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg <= bcm_pkg::UNIT_MIN;
        end else if (cfg_wr) begin
            tpu_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bcm_pkg::REG_TICKS_PER_UNIT) begin
            prdata = {24'd0, tpu_reg};
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the output register frees when the sink takes it
    // ---------------------------------------------------------------
    logic          m_valid_reg;
    bcm_pkg::out_t m_data_reg;
    logic          s_accept;

    assign s_ready  = ~m_valid_reg | m_ready;
    assign s_accept = s_valid & s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // ---------------------------------------------------------------
    // Display state
    // ---------------------------------------------------------------
    bcm_pkg::planes_t store_reg [2];   // [buffer][plane]
    logic                         front_reg;
    logic                         pending_reg;
    logic [bcm_pkg::SLICE_W-1:0]  slice_reg;
    logic [bcm_pkg::HOLD_W-1:0]   hold_reg;
    bcm_pkg::pattern_t            shown_reg;

    bcm_pkg::planes_t new_planes;

    bcm_transpose u_transpose (
        .req    (s_data),
        .planes (new_planes)
    );

    logic                         is_load;
    logic                         is_tick;
    logic                         load_ok;
    logic [7:0]                   unit;
    logic [bcm_pkg::HOLD_W-1:0]   duration;
    logic [bcm_pkg::HOLD_W:0]     count;
    logic                         slice_done;
    logic [bcm_pkg::SLICE_W-1:0]  slice_inc;
    logic                         do_swap;
    logic                         front_next;
    logic                         pending_next;
    logic [bcm_pkg::SLICE_W-1:0]  slice_next;
    logic [bcm_pkg::HOLD_W-1:0]   hold_next;
    bcm_pkg::pattern_t            shown_next;

    always_comb begin
        is_load = s_accept & (s_data.mode == bcm_pkg::MODE_LOAD);
        is_tick = s_accept & (s_data.mode == bcm_pkg::MODE_TICK);
        // refused while a loaded frame still waits for its swap
        load_ok = is_load & ~pending_reg;

        // zero setting behaves as a one-tick unit
        unit       = (tpu_reg == 8'd0) ? bcm_pkg::UNIT_MIN : tpu_reg;
        duration   = {8'd0, unit} << slice_reg;
        count      = {1'b0, hold_reg} + 17'd1;
        slice_done = count >= {1'b0, duration};
        slice_inc  = slice_reg + 3'd1;
        do_swap    = slice_done & (slice_inc == 3'd0) & pending_reg;

        front_next   = front_reg;
        pending_next = pending_reg;
        slice_next   = slice_reg;
        hold_next    = hold_reg;
        shown_next   = shown_reg;

        if (load_ok) begin
            pending_next = 1'b1;
        end else if (is_tick) begin
            if (slice_done) begin
                hold_next  = '0;
                slice_next = slice_inc;
                if (do_swap) begin
                    front_next   = ~front_reg;
                    pending_next = 1'b0;
                end
                // pattern latched on entry to the plane
                shown_next = store_reg[front_next][slice_inc];
            end else begin
                hold_next = count[bcm_pkg::HOLD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < 2; b++) begin
                store_reg[b] <= '0;
            end
            front_reg   <= 1'b0;
            pending_reg <= 1'b0;
            slice_reg   <= '0;
            hold_reg    <= '0;
            shown_reg   <= '0;
        end else begin
            if (load_ok) begin
                store_reg[~front_reg] <= new_planes;
            end
            front_reg   <= front_next;
            pending_reg <= pending_next;
            slice_reg   <= slice_next;
            hold_reg    <= hold_next;
            shown_reg   <= shown_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg.port_value <= shown_next;
            m_data_reg.slice_now  <= slice_next;
            m_data_reg.load_taken <= load_ok;
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_NEXT(a_refuse_pending, aclk, aresetn,
                 is_load && pending_reg,
                 m_data_reg.load_taken == 1'b0 && pending_reg,
                 "load taken while swap pending")
    `ASSERT_NEXT(a_slice_only_tick, aclk, aresetn,
                 !is_tick,
                 $stable(slice_reg) && $stable(front_reg),
                 "slice moved without a tick")
    `ASSERT_SAME(a_swap_at_wrap, aclk, aresetn,
                 !$stable(front_reg),
                 slice_reg == 3'd0 && !pending_reg,
                 "buffer swap away from frame start")

endmodule

`default_nettype wire

/* verif/bcm_frame_checker.sv */
// Watches both channels and the register port, keeps its own copy of the
// display state and checks every result against the oldest prediction.
module bcm_frame_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  bcm_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  bcm_pkg::out_t m_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    output int            mismatches,
    output int            results_pending,
    output int            results_checked
);

    localparam int SHOWN_MAX = 10;

    bcm_pkg::pattern_t                   frame_buf [2][bcm_pkg::NUM_PLANES];
    logic                                front_sel;
    logic                                swap_due;
    logic [bcm_pkg::SLICE_W-1:0]         plane_now;
    logic [bcm_pkg::HOLD_W-1:0]          ticks_in_plane;
    bcm_pkg::pattern_t                   lit_now;
    logic [7:0]                          unit_ticks;
    bcm_pkg::out_t                       port_expect_q [$];

    initial begin
        mismatches      = 0;
        results_pending = 0;
        results_checked = 0;
    end

    // one request's effect on the display; returns the port state after it
    task automatic advance_display(input bcm_pkg::in_t req, output bcm_pkg::out_t res);
        logic [bcm_pkg::NUM_LEDS-1:0][bcm_pkg::LEVEL_W-1:0] lv;
        bcm_pkg::pattern_t                                  bits;
        logic [bcm_pkg::HOLD_W:0]                           count;
        logic [bcm_pkg::HOLD_W-1:0]                         span;
        lv = {req.level_7, req.level_6, req.level_5, req.level_4,
              req.level_3, req.level_2, req.level_1, req.level_0};
        res.load_taken = 1'b0;
        if (req.mode == bcm_pkg::MODE_LOAD) begin
            // refused while the back buffer still waits to be shown
            if (!swap_due) begin
                for (int p = 0; p < bcm_pkg::NUM_PLANES; p++) begin
                    for (int n = 0; n < bcm_pkg::NUM_LEDS; n++)
                        bits[n] = req.led_mask[n] & lv[n][p];
                    frame_buf[!front_sel][p] = bits;
                end
                swap_due       = 1'b1;
                res.load_taken = 1'b1;
            end
        end else begin
            count = {1'b0, ticks_in_plane} + 1'b1;
            span  = bcm_pkg::HOLD_W'(unit_ticks == 8'd0 ? bcm_pkg::UNIT_MIN : unit_ticks)
                    << plane_now;
            if (count >= {1'b0, span}) begin
                ticks_in_plane = '0;
                plane_now      = plane_now + 1'b1;
                if (plane_now == '0 && swap_due) begin
                    front_sel = !front_sel;
                    swap_due  = 1'b0;
                end
                lit_now = frame_buf[front_sel][plane_now];
            end else begin
                ticks_in_plane = count[bcm_pkg::HOLD_W-1:0];
            end
        end
        res.port_value = lit_now;
        res.slice_now  = plane_now;
    endtask

    always @(posedge aclk) begin : watch
        bcm_pkg::out_t want;
        if (!aresetn) begin
            for (int b = 0; b < 2; b++)
                for (int p = 0; p < bcm_pkg::NUM_PLANES; p++)
                    frame_buf[b][p] = '0;
            front_sel      = 1'b0;
            swap_due       = 1'b0;
            plane_now      = '0;
            ticks_in_plane = '0;
            lit_now        = '0;
            unit_ticks     = bcm_pkg::UNIT_MIN;
            port_expect_q.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[2] == bcm_pkg::REG_TICKS_PER_UNIT)
                unit_ticks = pwdata[7:0];
            if (m_valid && m_ready) begin
                if (port_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX)
                        $display("[%0t] result with nothing outstanding: %s %02h %s %0d %s %0b",
                                 $time, "port", m_data.port_value,
                                 "slice", m_data.slice_now, "taken", m_data.load_taken);
                end else begin
                    want = port_expect_q.pop_front();
                    results_checked++;
                    if (m_data.port_value !== want.port_value ||
                        m_data.slice_now  !== want.slice_now  ||
                        m_data.load_taken !== want.load_taken) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MAX)
                            $display({"[%0t] mismatch: port %02h/%02h slice %0d/%0d",
                                      " taken %0b/%0b (exp/got)"},
                                     $time, want.port_value, m_data.port_value,
                                     want.slice_now, m_data.slice_now,
                                     want.load_taken, m_data.load_taken);
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_display(s_data, want);
                port_expect_q.push_back(want);
            end
        end
        results_pending <= port_expect_q.size();
    end

endmodule

/* verif/bcm_led_driver_tb.sv */
// Top of the LED driver bench: clock, reset, request and register traffic.
// All prediction and comparison lives in the checker beside the block.
module bcm_led_driver_tb;

    // register addresses: word index times four
    localparam logic [2:0] TPU_ADDR   = {bcm_pkg::REG_TICKS_PER_UNIT, 2'b00};
    localparam logic [2:0] SPARE_ADDR = 3'b100;   // word 1, nothing mapped there

    // budget covers ~1700 requests with idle gaps and sink stalls, plus the long hold
    localparam int RUN_LIMIT      = 400_000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_TAIL     = 4;           // margin after the final drain

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    bcm_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    bcm_pkg::out_t m_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    int            mismatches;
    int            results_pending;
    int            results_checked;

    logic          squeeze_req;    // asks the sink for one long hold-off
    logic          squeeze_done;
    logic          calm;           // no idling on either side from here on
    int            cycle_cnt = 0;
    int            sent_total = 0;
    int            ticks_sent = 0;

    always #5 aclk = ~aclk;

    bcm_led_driver u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bcm_frame_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result sink. Mixes ready stretches with random stall bursts; once asked,
    // holds off for a long count so the block backs up and drops s_ready
    // while requests keep coming.
    initial begin : result_sink
        int n;
        m_ready      = 1'b0;
        squeeze_done = 1'b0;
        forever begin
            if (squeeze_req && !squeeze_done) begin
                m_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
                squeeze_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 24);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // valid goes up with the payload and stays until the edge that takes it
    task automatic send(input bcm_pkg::in_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sent_total++;
        if (req.mode == bcm_pkg::MODE_TICK)
            ticks_sent++;
    endtask

    // sender pauses until every predicted result has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    // setup cycle, then access cycle; written at the access edge
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic bcm_pkg::in_t frame_req(
        input logic [bcm_pkg::NUM_LEDS-1:0]                      mask,
        input logic [bcm_pkg::NUM_LEDS-1:0][bcm_pkg::LEVEL_W-1:0] lv);
        bcm_pkg::in_t r;
        r.mode     = bcm_pkg::MODE_LOAD;
        r.led_mask = mask;
        {r.level_7, r.level_6, r.level_5, r.level_4,
         r.level_3, r.level_2, r.level_1, r.level_0} = lv;
        return r;
    endfunction

    // tick with its unused fields set to a fill value; they must not matter
    function automatic bcm_pkg::in_t tick_req(input logic fill);
        bcm_pkg::in_t r;
        r      = {$bits(bcm_pkg::in_t){fill}};
        r.mode = bcm_pkg::MODE_TICK;
        return r;
    endfunction

    // mostly ticks; loads carry random masks and levels leaning on the extremes
    function automatic bcm_pkg::in_t random_req(input int load_pct);
        bcm_pkg::in_t                                       r;
        logic [bcm_pkg::NUM_LEDS-1:0][bcm_pkg::LEVEL_W-1:0] lv;
        case ($urandom_range(0, 7))
            0:       r.led_mask = '0;
            1:       r.led_mask = '1;
            default: r.led_mask = bcm_pkg::NUM_LEDS'($urandom);
        endcase
        for (int n = 0; n < bcm_pkg::NUM_LEDS; n++) begin
            case ($urandom_range(0, 9))
                0:       lv[n] = '0;
                1:       lv[n] = '1;
                2:       lv[n] = bcm_pkg::LEVEL_W'(1) << $urandom_range(0, bcm_pkg::LEVEL_W - 1);
                default: lv[n] = bcm_pkg::LEVEL_W'($urandom);
            endcase
        end
        {r.level_7, r.level_6, r.level_5, r.level_4,
         r.level_3, r.level_2, r.level_1, r.level_0} = lv;
        r.mode = ($urandom_range(0, 99) < load_pct) ? bcm_pkg::MODE_LOAD : bcm_pkg::MODE_TICK;
        return r;
    endfunction

    task automatic run_phase(input int count, input int load_pct, input bit gaps);
        int n;
        repeat (count) begin
            send(random_req(load_pct));
            if (gaps && !calm && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge aclk);
            end
        end
    endtask

    initial begin : stimulus
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        squeeze_req = 1'b0;
        calm        = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, at the reset unit of one tick:
        // a tick from reset, a full-on frame, then two loads refused because
        // the swap is still pending (one all dark, one the transpose pattern),
        // then ticks with their ignored fields all ones and all zeros.
        send(tick_req(1'b0));
        send(frame_req(8'hFF, {bcm_pkg::NUM_LEDS{8'hFF}}));
        send(frame_req(8'h00, '0));
        send(frame_req(8'hFF, 64'h8040_2010_0804_0201));
        for (int i = 0; i < 16; i++)
            send(tick_req(i[0]));

        // unit of one written explicitly; long enough for a few full frames
        drain();
        reg_write(TPU_ADDR, 32'd1);
        run_phase(600, 10, 1'b1);

        // unit changed mid-slice; sink holds off while requests keep coming
        drain();
        reg_write(TPU_ADDR, 32'd2);
        squeeze_req <= 1'b1;
        run_phase(200, 10, 1'b0);

        // zero unit behaves as one; a write to the unmapped word is ignored
        drain();
        reg_write(TPU_ADDR, 32'd0);
        reg_write(SPARE_ADDR, 32'hC8);
        run_phase(250, 10, 1'b1);

        // largest unit: long slices, counter well up before the next change
        drain();
        reg_write(TPU_ADDR, 32'd255);
        run_phase(150, 20, 1'b1);

        // small unit after a large one: current slice ends on the next tick
        drain();
        reg_write(TPU_ADDR, 32'($urandom_range(1, 3)));
        run_phase(150, 10, 1'b1);

        // closing stretch at full rate, no idling either side
        drain();
        reg_write(TPU_ADDR, 32'd1);
        calm <= 1'b1;
        run_phase(300, 10, 1'b0);

        drain();
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("Drove %0d requests (%0d ticks, %0d loads) at units 0, 1, 2, 255 and one random.",
                 sent_total, ticks_sent, sent_total - ticks_sent);
        $display("Compared %0d results, %0d mismatched; one long sink hold-off included.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
